[rtl/core/mqtt_packet_deframer_top_macros.svh]
// Assertion helpers used by the deframer core RTL.
`ifndef MQTT_PACKET_DEFRAMER_TOP_MACROS_SVH
`define MQTT_PACKET_DEFRAMER_TOP_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define MPD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check a consequence in the clock after its trigger.
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 28;
    localparam int PID_W   = 16;
    localparam int GROUP_W = 7;

    localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

    localparam logic [3:0] MSG_PUBLISH     = 4'd3;
    localparam logic [3:0] MSG_PUBREL      = 4'd6;
    localparam logic [3:0] MSG_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] MSG_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] MSG_ID_FIRST    = 4'd4;
    localparam logic [3:0] MSG_ID_LAST     = 4'd11;
    localparam logic [3:0] FLAGS_FIXED     = 4'b0010;
    localparam logic [1:0] QOS_INVALID     = 2'd3;
    localparam logic [1:0] QOS_NONE        = 2'd0;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_HEADER = 2'd0,
        ROLE_LENGTH = 2'd1,
        ROLE_BODY   = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FLAGS = 2'd1,
        ERR_LEN   = 2'd2
    } t_err;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        t_role             byte_role;
        logic              packet_start;
        logic              packet_end;
        logic [3:0]        message_type;
        logic              dup_flag;
        logic [1:0]        qos_level;
        logic              retain_flag;
        logic [LEN_W-1:0]  remaining_length;
        logic [PID_W-1:0]  packet_id;
        logic              packet_id_valid;
        t_err              error_code;
    } t_result;

    function automatic logic flags_bad(input logic [BYTE_W-1:0] hdr);
        logic [3:0] kind;
        kind = hdr[7:4];
        flags_bad = (hdr[2:1] == QOS_INVALID)
                 || (((kind == MSG_PUBREL) || (kind == MSG_SUBSCRIBE)
                      || (kind == MSG_UNSUBSCRIBE)) && (hdr[3:0] != FLAGS_FIXED));
    endfunction

endpackage

`default_nettype wire

[rtl/core/mpd_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [mpd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mpd_pkg::BYTE_W-1:0] byte_out;
    logic [1:0]                 byte_role;
    logic                       packet_start;
    logic                       packet_end;
    logic [3:0]                 message_type;
    logic                       dup_flag;
    logic [1:0]                 qos_level;
    logic                       retain_flag;
    logic [mpd_pkg::LEN_W-1:0]  remaining_length;
    logic [mpd_pkg::PID_W-1:0]  packet_id;
    logic                       packet_id_valid;
    logic [1:0]                 error_code;

    modport source (
        output valid, output byte_out, output byte_role, output packet_start,
        output packet_end, output message_type, output dup_flag, output qos_level,
        output retain_flag, output remaining_length, output packet_id,
        output packet_id_valid, output error_code, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_role, input packet_start,
        input packet_end, input message_type, input dup_flag, input qos_level,
        input retain_flag, input remaining_length, input packet_id,
        input packet_id_valid, input error_code, output ready
    );
endinterface

`default_nettype wire

[rtl/core/mpd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module mpd_in_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mpd_in_if.sink            i_in,
    input  wire               i_take,
    output mpd_pkg::t_in_beat o_beat
);

    logic                       r_valid;
    logic                       n_valid;
    logic [mpd_pkg::BYTE_W-1:0] r_data;

    assign i_in.ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.data_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

`default_nettype wire

[rtl/core/mpd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mqtt_packet_deframer_top_macros.svh"

module mpd_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_step,
    input  wire [mpd_pkg::BYTE_W-1:0] i_byte,
    output mpd_pkg::t_result          o_res
);

    mpd_pkg::t_phase            r_phase, n_phase;
    logic [mpd_pkg::BYTE_W-1:0] r_hdr, n_hdr;
    logic [mpd_pkg::LEN_W-1:0]  r_len_acc, n_len_acc;
    logic [2:0]                 r_len_cnt, n_len_cnt;
    logic [mpd_pkg::LEN_W-1:0]  r_left, n_left;
    logic [mpd_pkg::LEN_W-1:0]  r_idx, n_idx;
    logic [mpd_pkg::PID_W-1:0]  r_topic, n_topic;
    logic [mpd_pkg::BYTE_W-1:0] r_id_hi, n_id_hi;
    logic                       r_err_lat, n_err_lat;

    logic                       len_over;
    logic [mpd_pkg::LEN_W-1:0]  len_group;
    logic [mpd_pkg::LEN_W-1:0]  len_sum;
    logic [mpd_pkg::LEN_W-1:0]  topic_p2;
    logic [mpd_pkg::LEN_W-1:0]  topic_p3;
    logic [mpd_pkg::BYTE_W-1:0] eff_hdr;
    logic [3:0]                 hdr_kind;
    logic [1:0]                 hdr_qos;

    assign len_over = (r_len_cnt >= mpd_pkg::LEN_BYTES_MAX);
    assign len_sum  = r_len_acc + len_group;
    assign topic_p2 = mpd_pkg::LEN_W'(r_topic) + mpd_pkg::LEN_W'(2);
    assign topic_p3 = mpd_pkg::LEN_W'(r_topic) + mpd_pkg::LEN_W'(3);
    assign eff_hdr  = (r_phase == mpd_pkg::PH_HEADER) ? i_byte : r_hdr;
    assign hdr_kind = r_hdr[7:4];
    assign hdr_qos  = r_hdr[2:1];

    always_comb begin
        case (r_len_cnt[1:0])
            2'd0:    len_group = {21'b0, i_byte[6:0]};
            2'd1:    len_group = {14'b0, i_byte[6:0], 7'b0};
            2'd2:    len_group = {7'b0, i_byte[6:0], 14'b0};
            default: len_group = {i_byte[6:0], 21'b0};
        endcase
    end

    always_comb begin : next_state
        n_phase = r_phase;
        if (i_step && !r_err_lat) begin
            case (r_phase)
                mpd_pkg::PH_HEADER: begin
                    n_phase = mpd_pkg::PH_LENGTH;
                end
                mpd_pkg::PH_LENGTH: begin
                    if (!len_over && !i_byte[7]) begin
                        n_phase = (len_sum == '0) ? mpd_pkg::PH_HEADER : mpd_pkg::PH_BODY;
                    end
                end
                mpd_pkg::PH_BODY: begin
                    if (r_left == mpd_pkg::LEN_W'(1)) begin
                        n_phase = mpd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    n_phase = mpd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin : outputs
        n_hdr     = r_hdr;
        n_len_acc = r_len_acc;
        n_len_cnt = r_len_cnt;
        n_left    = r_left;
        n_idx     = r_idx;
        n_topic   = r_topic;
        n_id_hi   = r_id_hi;
        n_err_lat = r_err_lat;

        o_res                  = '0;
        o_res.byte_out         = i_byte;
        o_res.message_type     = eff_hdr[7:4];
        o_res.dup_flag         = eff_hdr[3];
        o_res.qos_level        = eff_hdr[2:1];
        o_res.retain_flag      = eff_hdr[0];
        o_res.remaining_length = r_len_acc;
        o_res.error_code       = mpd_pkg::flags_bad(eff_hdr) ? mpd_pkg::ERR_FLAGS
                                                              : mpd_pkg::ERR_NONE;

        if (r_err_lat || ((r_phase == mpd_pkg::PH_LENGTH) && len_over)) begin
            n_err_lat                = 1'b1;
            o_res                    = '0;
            o_res.byte_out           = i_byte;
            o_res.byte_role          = mpd_pkg::ROLE_BODY;
            o_res.error_code         = mpd_pkg::ERR_LEN;
        end else begin
            case (r_phase)
                mpd_pkg::PH_HEADER: begin
                    n_hdr                  = i_byte;
                    n_len_acc              = '0;
                    n_len_cnt              = '0;
                    n_left                 = '0;
                    n_idx                  = '0;
                    n_topic                = '0;
                    o_res.byte_role        = mpd_pkg::ROLE_HEADER;
                    o_res.packet_start     = 1'b1;
                    o_res.remaining_length = '0;
                end
                mpd_pkg::PH_LENGTH: begin
                    n_len_acc              = len_sum;
                    n_len_cnt              = r_len_cnt + 3'd1;
                    o_res.byte_role        = mpd_pkg::ROLE_LENGTH;
                    o_res.remaining_length = len_sum;
                    if (!i_byte[7]) begin
                        if (len_sum == '0) begin
                            o_res.packet_end = 1'b1;
                        end else begin
                            n_left = len_sum;
                            n_idx  = '0;
                        end
                    end
                end
                mpd_pkg::PH_BODY: begin
                    o_res.byte_role = mpd_pkg::ROLE_BODY;
                    if ((hdr_kind >= mpd_pkg::MSG_ID_FIRST)
                            && (hdr_kind <= mpd_pkg::MSG_ID_LAST)) begin
                        if (r_idx == '0) begin
                            n_id_hi = i_byte;
                        end else if (r_idx == mpd_pkg::LEN_W'(1)) begin
                            o_res.packet_id       = {r_id_hi, i_byte};
                            o_res.packet_id_valid = 1'b1;
                        end
                    end else if ((hdr_kind == mpd_pkg::MSG_PUBLISH)
                            && (hdr_qos != mpd_pkg::QOS_NONE)) begin
                        if (r_idx == '0) begin
                            n_id_hi = i_byte;
                        end else if (r_idx == mpd_pkg::LEN_W'(1)) begin
                            n_topic = {r_id_hi, i_byte};
                        end else if (r_idx == topic_p2) begin
                            n_id_hi = i_byte;
                        end else if (r_idx == topic_p3) begin
                            o_res.packet_id       = {r_id_hi, i_byte};
                            o_res.packet_id_valid = 1'b1;
                        end
                    end
                    n_idx  = r_idx + mpd_pkg::LEN_W'(1);
                    n_left = r_left - mpd_pkg::LEN_W'(1);
                    if (r_left == mpd_pkg::LEN_W'(1)) begin
                        o_res.packet_end = 1'b1;
                    end
                end
                default: begin
                    o_res.byte_role = mpd_pkg::ROLE_BODY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mpd_pkg::PH_HEADER;
            r_hdr     <= '0;
            r_len_acc <= '0;
            r_len_cnt <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_topic   <= '0;
            r_id_hi   <= '0;
            r_err_lat <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_len_acc <= n_len_acc;
            r_len_cnt <= n_len_cnt;
            r_left    <= n_left;
            r_idx     <= n_idx;
            r_topic   <= n_topic;
            r_id_hi   <= n_id_hi;
            r_err_lat <= n_err_lat;
        end
    end

    `MPD_ASSERT_NEXT(a_err_sticky, r_err_lat, r_err_lat, "length error cleared without reset")
    `MPD_ASSERT_ALWAYS(a_len_cnt_max, r_len_cnt <= mpd_pkg::LEN_BYTES_MAX,
        "length byte count beyond limit")
    `MPD_ASSERT_ALWAYS(a_body_left, (r_phase != mpd_pkg::PH_BODY) || (r_left != '0),
        "body phase with no bytes left")
    `MPD_ASSERT_NEXT(a_len_step, i_step && (r_phase == mpd_pkg::PH_HEADER) && !r_err_lat,
        (r_phase == mpd_pkg::PH_LENGTH) && (r_len_cnt == '0), "header not followed by length")

endmodule

`default_nettype wire

[rtl/core/mpd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module mpd_out_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  wire mpd_pkg::t_result i_res,
    output logic                  o_can_load,
    mpd_out_if.source             o_out
);

    logic             r_valid;
    logic             n_valid;
    mpd_pkg::t_result r_res;

    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.byte_out         = r_res.byte_out;
    assign o_out.byte_role        = r_res.byte_role;
    assign o_out.packet_start     = r_res.packet_start;
    assign o_out.packet_end       = r_res.packet_end;
    assign o_out.message_type     = r_res.message_type;
    assign o_out.dup_flag         = r_res.dup_flag;
    assign o_out.qos_level        = r_res.qos_level;
    assign o_out.retain_flag      = r_res.retain_flag;
    assign o_out.remaining_length = r_res.remaining_length;
    assign o_out.packet_id        = r_res.packet_id;
    assign o_out.packet_id_valid  = r_res.packet_id_valid;
    assign o_out.error_code       = r_res.error_code;

endmodule

`default_nettype wire

[rtl/core/mqtt_packet_deframer_top.sv]
// Path: a byte accepted into the input register is decoded combinationally by the
// core, and its result is loaded into the result register and offered from there.
// Throughput: one byte per cycle while the output is not stalled; input register,
// decode stage and result register step together; an output stall holds all three.
// Reset: i_rst_n synchronous, active low; clears framing state and the sticky
// length error, empties both registers; the block accepts bytes right after.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_deframer_top (
    input  wire       i_clk,
    input  wire       i_rst_n,
    mpd_in_if.sink    i_in,
    mpd_out_if.source o_out
);

    mpd_pkg::t_in_beat beat;
    mpd_pkg::t_result  res;
    logic              can_load;
    logic              step;

    assign step = beat.valid && can_load;

    mpd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (can_load),
        .o_beat  (beat)
    );

    mpd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (beat.data),
        .o_res   (res)
    );

    mpd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
